// File: rtl/rwab_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwab_pkg: shared types and constants for the reorder window
// Result kinds, controller states, and the command/status bundles that join
// the controller to the datapath.
// ----------------------------------------------------------------------------
package rwab_pkg;

   // Id space is 16 bits; the expected id may sit one past it.
   localparam logic [16:0] ID_SPACE        = 17'h10000;
   localparam logic [5:0]  ACK_LIMIT_RESET = 6'd32;

   localparam logic OP_ARRIVAL = 1'b0;
   localparam logic OP_ACK     = 1'b1;

   typedef enum logic [2:0] {
      KIND_DELIVERED = 3'd0,
      KIND_HELD      = 3'd1,
      KIND_STALE     = 3'd2,
      KIND_DUP       = 3'd3,
      KIND_BEYOND    = 3'd4,
      KIND_ACK       = 3'd5,
      KIND_NO_ACK    = 3'd6
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DRAIN,
      ST_SCAN,
      ST_ACK_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic drain;
      logic scan;
      logic ack_out;
   } cmd_type;

   typedef struct packed {
      logic go_drain;
      logic go_scan;
      logic drain_more;
      logic scan_done;
   } status_type;

endpackage

// File: rtl/rwab_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwab_ctrl: sequencer for the reorder window
// Takes one request at a time, steps the datapath through classify, in-order
// drain and ack bitmap scan.
// ----------------------------------------------------------------------------
module rwab_ctrl
   import rwab_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output logic       busy,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = start;
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (status.go_drain) begin
               state_in = ST_DRAIN;
            end else if (status.go_scan) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DRAIN: begin
            cmd.drain = 1'b1;
            if (!status.drain_more) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               state_in = ST_ACK_OUT;
            end
         end
         ST_ACK_OUT: begin
            cmd.ack_out = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   // a drain run only ever follows an in-order delivery
   a_drain_entry: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAIN |->
         ($past(state_ff) == ST_EXEC || $past(state_ff) == ST_DRAIN))
      else $error("drain entered without an in-order delivery");

endmodule

// File: rtl/rwab_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwab_dp: reorder window datapath
// Expected id, held marks, held tag memory, ack flag and limit, ack scan
// accumulators and the result output register.
// ----------------------------------------------------------------------------
module rwab_dp
   import rwab_pkg::*;
#(
   parameter int WINDOW  = 32,
   parameter int ACK_MAX = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic        req_opcode,
   input  logic [15:0] req_packet_id,
   input  logic [15:0] req_buffer_tag,
   input  logic        csr_wr_en,
   input  logic [5:0]  csr_wr_data,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_kind,
   output logic [15:0] rsp_delivered_id,
   output logic [15:0] rsp_delivered_tag,
   output logic [16:0] rsp_ack_base,
   output logic [5:0]  rsp_ack_count,
   output logic [31:0] rsp_ack_bitmap,
   output logic        rsp_last
);

   localparam int SW = $clog2(WINDOW);
   localparam int NW = $clog2(WINDOW + 1);
   localparam int CW = (SW + 1 > 6) ? SW + 1 : 6;
   localparam int LIM_CAP = (ACK_MAX < 32) ? ACK_MAX : 32;

   localparam logic [SW:0]   WIN_EXT  = (SW + 1)'(WINDOW);
   localparam logic [16:0]   WIN_17   = 17'(WINDOW);
   localparam logic [SW-1:0] ONE_S    = SW'(1);
   localparam logic [SW-1:0] D_LAST   = SW'(WINDOW - 1);
   localparam logic [SW:0]   SPAN_ONE = (SW + 1)'(1);
   localparam logic [NW-1:0] CNT_ONE  = NW'(1);
   localparam logic [NW-1:0] CNT_LAST = NW'(WINDOW - 1);
   localparam logic [5:0]    LIM_CAP6 = 6'(LIM_CAP);

   function automatic logic [SW-1:0] wrap_add(input logic [SW-1:0] a,
                                              input logic [SW-1:0] b);
      logic [SW:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= WIN_EXT) begin
         s = s - WIN_EXT;
      end
      return s[SW-1:0];
   endfunction

   // latched request
   logic        op_ff;
   logic [15:0] id_ff;
   logic [15:0] tag_ff;

   // window state
   logic [16:0]       exp_ff,  exp_in;
   logic [SW-1:0]     slot_ff, slot_in;
   logic              pend_ff, pend_in;
   logic [WINDOW-1:0] mark_ff, mark_in;
   logic [5:0]        lim_ff,  lim_in;
   logic [NW-1:0]     cnt_ff,  cnt_in;

   // ack scan
   logic [SW-1:0] d_ff,    d_in;
   logic [SW:0]   span_ff, span_in;
   logic [31:0]   bmp_ff,  bmp_in;

   // held tag memory
   logic [15:0] tag_mem [WINDOW];
   logic [15:0] mem_q_ff;
   logic        mem_we;

   // result register
   logic        strobe_ff, strobe_in;
   kind_type    kind_ff,   kind_in;
   logic [15:0] rid_ff,    rid_in;
   logic [15:0] rtag_ff,   rtag_in;
   logic [16:0] base_ff,   base_in;
   logic [5:0]  count_ff,  count_in;
   logic [31:0] rbmp_ff,   rbmp_in;
   logic        last_ff,   last_in;

   // classification
   logic [16:0]   id_ext;
   logic [16:0]   diff;
   logic [16:0]   nexp;
   logic          stale;
   logic          equal;
   logic          beyond;
   logic          nexp_ok;
   logic [SW-1:0] nslot;
   logic [SW-1:0] hslot;
   logic [SW-1:0] scan_idx;
   logic          cont_exec;
   logic          cont_drain;
   logic [5:0]    lim;
   logic [CW-1:0] dx;
   logic [CW-1:0] span_x;
   logic [CW-1:0] lim_x;
   logic [5:0]    ack_cnt;

   always_comb begin
      id_ext     = {1'b0, id_ff};
      diff       = id_ext - exp_ff;
      nexp       = exp_ff + 17'd1;
      stale      = id_ext < exp_ff;
      equal      = id_ext == exp_ff;
      beyond     = diff >= WIN_17;
      nexp_ok    = nexp < ID_SPACE;
      nslot      = wrap_add(slot_ff, ONE_S);
      hslot      = wrap_add(slot_ff, diff[SW-1:0]);
      scan_idx   = wrap_add(slot_ff, d_ff);
      cont_exec  = nexp_ok && mark_ff[nslot];
      cont_drain = nexp_ok && mark_ff[nslot] && (cnt_ff < CNT_LAST);
      lim        = (lim_ff > LIM_CAP6) ? LIM_CAP6 : lim_ff;
      dx         = CW'(d_ff);
      span_x     = CW'(span_ff);
      lim_x      = CW'(lim);
      ack_cnt    = (span_x < lim_x) ? 6'(span_x) : lim;
   end

   assign status.go_drain   = (op_ff == OP_ARRIVAL) && equal && cont_exec;
   assign status.go_scan    = (op_ff == OP_ACK) && pend_ff;
   assign status.drain_more = cont_drain;
   assign status.scan_done  = (d_ff == D_LAST);

   assign mem_we = cmd.exec && (op_ff == OP_ARRIVAL) && !stale && !equal && !beyond
                   && !mark_ff[hslot];

   always_comb begin
      exp_in    = exp_ff;
      slot_in   = slot_ff;
      pend_in   = pend_ff;
      mark_in   = mark_ff;
      lim_in    = lim_ff;
      cnt_in    = cnt_ff;
      d_in      = d_ff;
      span_in   = span_ff;
      bmp_in    = bmp_ff;
      strobe_in = 1'b0;
      kind_in   = kind_ff;
      rid_in    = rid_ff;
      rtag_in   = rtag_ff;
      base_in   = base_ff;
      count_in  = count_ff;
      rbmp_in   = rbmp_ff;
      last_in   = last_ff;

      if (csr_wr_en) begin
         lim_in = csr_wr_data;
      end

      if (cmd.exec) begin
         strobe_in = 1'b1;
         last_in   = 1'b1;
         rid_in    = id_ff;
         rtag_in   = tag_ff;
         base_in   = '0;
         count_in  = '0;
         rbmp_in   = '0;
         if (op_ff == OP_ACK) begin
            rid_in  = '0;
            rtag_in = '0;
            if (pend_ff) begin
               // result goes out after the scan
               strobe_in = 1'b0;
               pend_in   = 1'b0;
               d_in      = ONE_S;
               span_in   = '0;
               bmp_in    = '0;
            end else begin
               kind_in = KIND_NO_ACK;
            end
         end else if (stale) begin
            kind_in = KIND_STALE;
         end else begin
            pend_in = 1'b1;
            if (equal) begin
               kind_in = KIND_DELIVERED;
               exp_in  = nexp;
               slot_in = nslot;
               cnt_in  = CNT_ONE;
               last_in = !cont_exec;
            end else if (beyond) begin
               kind_in = KIND_BEYOND;
            end else if (mark_ff[hslot]) begin
               kind_in = KIND_DUP;
            end else begin
               kind_in        = KIND_HELD;
               mark_in[hslot] = 1'b1;
            end
         end
      end

      if (cmd.drain) begin
         strobe_in        = 1'b1;
         kind_in          = KIND_DELIVERED;
         rid_in           = exp_ff[15:0];
         rtag_in          = mem_q_ff;
         base_in          = '0;
         count_in         = '0;
         rbmp_in          = '0;
         last_in          = !cont_drain;
         mark_in[slot_ff] = 1'b0;
         exp_in           = nexp;
         slot_in          = nslot;
         cnt_in           = cnt_ff + CNT_ONE;
      end

      if (cmd.scan) begin
         if (mark_ff[scan_idx]) begin
            span_in = {1'b0, d_ff} + SPAN_ONE;
            if (dx < lim_x) begin
               bmp_in[dx[4:0]] = 1'b1;
            end
         end
         d_in = d_ff + ONE_S;
      end

      if (cmd.ack_out) begin
         strobe_in = 1'b1;
         kind_in   = KIND_ACK;
         rid_in    = '0;
         rtag_in   = '0;
         base_in   = exp_ff;
         count_in  = ack_cnt;
         rbmp_in   = bmp_ff;
         last_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_opcode;
         id_ff  <= req_packet_id;
         tag_ff <= req_buffer_tag;
      end
   end

   // next drain slot is read every cycle; data lands in the mem_q_ff register
   always_ff @(posedge clock) begin
      if (mem_we) begin
         tag_mem[hslot] <= tag_ff;
      end
      mem_q_ff <= tag_mem[nslot];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ff    <= '0;
         slot_ff   <= '0;
         pend_ff   <= 1'b0;
         mark_ff   <= '0;
         lim_ff    <= ACK_LIMIT_RESET;
         cnt_ff    <= '0;
         d_ff      <= '0;
         span_ff   <= '0;
         bmp_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         exp_ff    <= exp_in;
         slot_ff   <= slot_in;
         pend_ff   <= pend_in;
         mark_ff   <= mark_in;
         lim_ff    <= lim_in;
         cnt_ff    <= cnt_in;
         d_ff      <= d_in;
         span_ff   <= span_in;
         bmp_ff    <= bmp_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      rid_ff   <= rid_in;
      rtag_ff  <= rtag_in;
      base_ff  <= base_in;
      count_ff <= count_in;
      rbmp_ff  <= rbmp_in;
      last_ff  <= last_in;
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_delivered_id  = rid_ff;
   assign rsp_delivered_tag = rtag_ff;
   assign rsp_ack_base      = base_ff;
   assign rsp_ack_count     = count_ff;
   assign rsp_ack_bitmap    = rbmp_ff;
   assign rsp_last          = last_ff;

   // expected slot is only marked while its held entry is being drained
   a_expected_unmarked: assert property (@(posedge clock) disable iff (reset)
      !mark_ff[slot_ff] || cmd.drain)
      else $error("expected slot marked outside a drain");

   a_expected_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> exp_ff >= $past(exp_ff))
      else $error("expected id moved backward");

   a_multi_is_delivery: assert property (@(posedge clock) disable iff (reset)
      strobe_ff && !last_ff |-> kind_ff == KIND_DELIVERED)
      else $error("non-final beat that is not a delivery");

endmodule

// File: rtl/reorder_window_with_ack_bitmap.sv
`timescale 1ns / 1ps
// Sequence: start is taken in IDLE and the request is classified in EXEC, whose result
//   beat is registered; drained ids follow one beat per cycle. An ack with the pending
//   flag set instead walks the WINDOW-1 held marks one per cycle, and its beat is
//   registered out of ACK_OUT. Requests are taken one at a time: busy is high until
//   the last beat is loaded, and start is not taken while busy.
// Reset: expected id, held marks, ack flag cleared, ack_limit set to 32; tag memory
//   is not cleared. Result beats are strobed for one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
// reorder_window_with_ack_bitmap: receive reorder window with selective ack
// In-order delivery of sequence ids with a held-id window and bitmap acks.
// ----------------------------------------------------------------------------
module reorder_window_with_ack_bitmap
   import rwab_pkg::*;
#(
   parameter int WINDOW  = 32,
   parameter int ACK_MAX = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_opcode,
   input  logic [15:0] req_packet_id,
   input  logic [15:0] req_buffer_tag,
   input  logic        csr_wr_en,
   input  logic [5:0]  csr_wr_data,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_kind,
   output logic [15:0] rsp_delivered_id,
   output logic [15:0] rsp_delivered_tag,
   output logic [16:0] rsp_ack_base,
   output logic [5:0]  rsp_ack_count,
   output logic [31:0] rsp_ack_bitmap,
   output logic        rsp_last
);

   cmd_type    cmd;
   status_type status;

   rwab_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   rwab_dp #(
      .WINDOW  (WINDOW),
      .ACK_MAX (ACK_MAX)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_opcode        (req_opcode),
      .req_packet_id     (req_packet_id),
      .req_buffer_tag    (req_buffer_tag),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_strobe        (rsp_strobe),
      .rsp_kind          (rsp_kind),
      .rsp_delivered_id  (rsp_delivered_id),
      .rsp_delivered_tag (rsp_delivered_tag),
      .rsp_ack_base      (rsp_ack_base),
      .rsp_ack_count     (rsp_ack_count),
      .rsp_ack_bitmap    (rsp_ack_bitmap),
      .rsp_last          (rsp_last)
   );

endmodule

// File: sim/reorder_window_with_ack_bitmap_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reorder_window_with_ack_bitmap_tb: self-checking bench for the reorder window
// A table of directed beats, then shuffled id bursts mixed with stale,
// duplicate, out-of-window and ack beats under several ack limits, then a
// short in-order run without gaps. Every result beat is checked field by
// field against its typed table row or a behavioral model of the window kept in the bench.
// ----------------------------------------------------------------------------
module reorder_window_with_ack_bitmap_tb
   import rwab_pkg::*;
();

   localparam int WINDOW      = 32;
   localparam int ACK_MAX     = 32;
   localparam int STALL_LIMIT = 2000;
   localparam int PHASE_ITEMS = 20;
   localparam int TAIL_ITEMS  = 30;
   localparam int DUE_DEPTH   = 4 * WINDOW;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] id;
      logic [15:0] tag;
      logic [16:0] base;
      logic [5:0]  count;
      logic [31:0] bitmap;
      logic        last;
   } window_result_type;

   typedef struct packed {
      logic              op;
      logic [15:0]       id;
      logic [15:0]       tag;
      logic              typed;
      window_result_type want;
   } stim_row_type;

   localparam window_result_type UNTYPED =
      '{KIND_DELIVERED, 16'h0, 16'h0, 17'h0, 6'd0, 32'h0, 1'b0};

   // expected beats that can be read straight off the spec are typed in
   stim_row_type plan [20] = '{
      '{OP_ACK,     16'h0000, 16'h0000, 1'b1,
        '{KIND_NO_ACK,    16'h0000, 16'h0000, 17'h0, 6'd0, 32'h0, 1'b1}},
      '{OP_ARRIVAL, 16'h0000, 16'hFFFF, 1'b1,
        '{KIND_DELIVERED, 16'h0000, 16'hFFFF, 17'h0, 6'd0, 32'h0, 1'b1}},
      '{OP_ARRIVAL, 16'h0000, 16'h0000, 1'b1,
        '{KIND_STALE,     16'h0000, 16'h0000, 17'h0, 6'd0, 32'h0, 1'b1}},
      '{OP_ARRIVAL, 16'hFFFF, 16'h1234, 1'b1,
        '{KIND_BEYOND,    16'hFFFF, 16'h1234, 17'h0, 6'd0, 32'h0, 1'b1}},
      '{OP_ACK,     16'hFFFF, 16'hFFFF, 1'b1,
        '{KIND_ACK,       16'h0000, 16'h0000, 17'h1, 6'd0, 32'h0, 1'b1}},
      '{OP_ACK,     16'h0000, 16'h0000, 1'b1,
        '{KIND_NO_ACK,    16'h0000, 16'h0000, 17'h0, 6'd0, 32'h0, 1'b1}},
      '{OP_ARRIVAL, 16'd32,   16'hA5A5, 1'b1,
        '{KIND_HELD,      16'd32,   16'hA5A5, 17'h0, 6'd0, 32'h0, 1'b1}},
      '{OP_ARRIVAL, 16'd33,   16'h0001, 1'b1,
        '{KIND_BEYOND,    16'd33,   16'h0001, 17'h0, 6'd0, 32'h0, 1'b1}},
      '{OP_ARRIVAL, 16'd32,   16'h5A5A, 1'b1,
        '{KIND_DUP,       16'd32,   16'h5A5A, 17'h0, 6'd0, 32'h0, 1'b1}},
      '{OP_ARRIVAL, 16'd2,    16'h0002, 1'b1,
        '{KIND_HELD,      16'd2,    16'h0002, 17'h0, 6'd0, 32'h0, 1'b1}},
      '{OP_ACK,     16'h0000, 16'h0000, 1'b1,
        '{KIND_ACK,       16'h0000, 16'h0000, 17'h1, 6'd32, 32'h8000_0002, 1'b1}},
      '{OP_ARRIVAL, 16'd3,    16'h0003, 1'b0, UNTYPED},
      '{OP_ARRIVAL, 16'd1,    16'h0001, 1'b0, UNTYPED},
      '{OP_ACK,     16'h0000, 16'h0000, 1'b0, UNTYPED},
      '{OP_ARRIVAL, 16'd3,    16'hFFFF, 1'b1,
        '{KIND_STALE,     16'd3,    16'hFFFF, 17'h0, 6'd0, 32'h0, 1'b1}},
      // a stale arrival leaves the ack flag clear
      '{OP_ACK,     16'h0000, 16'h0000, 1'b1,
        '{KIND_NO_ACK,    16'h0000, 16'h0000, 17'h0, 6'd0, 32'h0, 1'b1}},
      '{OP_ARRIVAL, 16'hFFFF, 16'h0000, 1'b1,
        '{KIND_BEYOND,    16'hFFFF, 16'h0000, 17'h0, 6'd0, 32'h0, 1'b1}},
      // last slot inside the window, then first slot past it
      '{OP_ARRIVAL, 16'd35,   16'h0035, 1'b0, UNTYPED},
      '{OP_ARRIVAL, 16'd36,   16'h0036, 1'b1,
        '{KIND_BEYOND,    16'd36,   16'h0036, 17'h0, 6'd0, 32'h0, 1'b1}},
      '{OP_ACK,     16'h0000, 16'h0000, 1'b0, UNTYPED}
   };

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_opcode;
   logic [15:0] req_packet_id;
   logic [15:0] req_buffer_tag;
   logic        csr_wr_en;
   logic [5:0]  csr_wr_data;
   logic        rsp_strobe;
   logic [2:0]  rsp_kind;
   logic [15:0] rsp_delivered_id;
   logic [15:0] rsp_delivered_tag;
   logic [16:0] rsp_ack_base;
   logic [5:0]  rsp_ack_count;
   logic [31:0] rsp_ack_bitmap;
   logic        rsp_last;

   // window model
   logic [16:0] exp_id = 17'd0;
   bit          held_mark [WINDOW];
   logic [15:0] held_tag [WINDOW];
   bit          ack_pend = 1'b0;
   logic [5:0]  ack_lim = ACK_LIMIT_RESET;

   // results of one step, then the ring of beats still to come
   window_result_type step_buf [WINDOW];
   int                step_n = 0;
   window_result_type due_buf [DUE_DEPTH];
   int                due_wr = 0;
   int                due_rd = 0;

   int  items_sent = 0;
   int  stall_cycles = 0;
   bit  sender_gaps = 1'b0;
   bit  failed = 1'b0;

   reorder_window_with_ack_bitmap #(
      .WINDOW (WINDOW),
      .ACK_MAX(ACK_MAX)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_packet_id    (req_packet_id),
      .req_buffer_tag   (req_buffer_tag),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_kind         (rsp_kind),
      .rsp_delivered_id (rsp_delivered_id),
      .rsp_delivered_tag(rsp_delivered_tag),
      .rsp_ack_base     (rsp_ack_base),
      .rsp_ack_count    (rsp_ack_count),
      .rsp_ack_bitmap   (rsp_ack_bitmap),
      .rsp_last         (rsp_last)
   );

   always #5 clock = ~clock;

   function automatic void emit(kind_type kind, logic [15:0] id, logic [15:0] tag,
                                logic [16:0] base, logic [5:0] count,
                                logic [31:0] bitmap);
      step_buf[step_n] = '{kind, id, tag, base, count, bitmap, 1'b0};
      step_n++;
   endfunction

   function automatic void due_put(window_result_type r);
      due_buf[due_wr % DUE_DEPTH] = r;
      due_wr++;
   endfunction

   function automatic window_result_type due_take();
      window_result_type r;
      r = due_buf[due_rd % DUE_DEPTH];
      due_rd++;
      return r;
   endfunction

   function automatic void window_arrival(logic [15:0] id, logic [15:0] tag);
      int n;
      int slot;
      n = 0;
      slot = id % WINDOW;
      if ({1'b0, id} < exp_id) begin
         emit(KIND_STALE, id, tag, 17'd0, 6'd0, 32'd0);
         return;
      end
      ack_pend = 1'b1;
      if ({1'b0, id} == exp_id) begin
         emit(KIND_DELIVERED, id, tag, 17'd0, 6'd0, 32'd0);
         exp_id++;
         n = 1;
         // drain held ids that follow on without a gap; no wrap past the id space
         while (exp_id < ID_SPACE && n < WINDOW && held_mark[exp_id % WINDOW]) begin
            held_mark[exp_id % WINDOW] = 1'b0;
            emit(KIND_DELIVERED, exp_id[15:0], held_tag[exp_id % WINDOW],
                 17'd0, 6'd0, 32'd0);
            exp_id++;
            n++;
         end
      end else if ({1'b0, id} - exp_id >= 17'(WINDOW)) begin
         emit(KIND_BEYOND, id, tag, 17'd0, 6'd0, 32'd0);
      end else if (held_mark[slot]) begin
         emit(KIND_DUP, id, tag, 17'd0, 6'd0, 32'd0);
      end else begin
         held_mark[slot] = 1'b1;
         held_tag[slot] = tag;
         emit(KIND_HELD, id, tag, 17'd0, 6'd0, 32'd0);
      end
   endfunction

   function automatic void window_ack();
      int span;
      int cap;
      int cnt;
      logic [31:0] bm;
      if (!ack_pend) begin
         emit(KIND_NO_ACK, 16'd0, 16'd0, 17'd0, 6'd0, 32'd0);
         return;
      end
      ack_pend = 1'b0;
      span = 0;
      bm = '0;
      for (int d = 1; d < WINDOW; d++) begin
         if (held_mark[(exp_id + d) % WINDOW]) span = d + 1;
      end
      cap = int'(ack_lim);
      if (cap > ACK_MAX) cap = ACK_MAX;
      if (cap > 32) cap = 32;
      cnt = (span < cap) ? span : cap;
      for (int d = 0; d < cnt; d++) begin
         if (held_mark[(exp_id + d) % WINDOW]) bm[d] = 1'b1;
      end
      emit(KIND_ACK, 16'd0, 16'd0, exp_id, 6'(cnt), bm);
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         failed = 1'b1;
      end
   endfunction

   // Drive one beat at the falling edge and hold it until taken.
   task automatic send_item(logic op, logic [15:0] id, logic [15:0] tag,
                            logic typed, window_result_type typed_res);
      window_result_type r;
      if (sender_gaps && $urandom_range(0, 2) == 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat ($urandom_range(0, 2)) @(negedge clock);
      end
      @(negedge clock);
      start          <= 1'b1;
      req_opcode     <= op;
      req_packet_id  <= id;
      req_buffer_tag <= tag;
      do @(posedge clock); while (busy);
      items_sent++;
      step_n = 0;
      if (op == OP_ARRIVAL) window_arrival(id, tag);
      else window_ack();
      if (typed) begin
         due_put(typed_res);
      end else begin
         for (int i = 0; i < step_n; i++) begin
            r = step_buf[i];
            r.last = (i == step_n - 1);
            due_put(r);
         end
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (due_wr != due_rd || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Ids from the expected id on, shuffled, with noise beats mixed in when noisy is set.
   task automatic window_burst(int k, bit noisy);
      logic [15:0] ids [WINDOW];
      logic [15:0] t;
      logic [16:0] base;
      int j;
      base = exp_id;
      for (int i = 0; i < k; i++) ids[i] = 16'(base + 17'(i));
      for (int i = k - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         t = ids[i];
         ids[i] = ids[j];
         ids[j] = t;
      end
      // often hold everything back so the base beat drains the whole run
      if ($urandom_range(0, 3) == 0) begin
         for (int i = 0; i < k; i++) begin
            if (ids[i] == base[15:0]) begin
               ids[i] = ids[k - 1];
               ids[k - 1] = base[15:0];
            end
         end
      end
      for (int i = 0; i < k; i++) begin
         if (noisy && $urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 4))
               0: send_item(OP_ACK, 16'($urandom), 16'($urandom), 1'b0, UNTYPED);
               1: begin
                  if (exp_id != 0)
                     send_item(OP_ARRIVAL, 16'($urandom_range(0, int'(exp_id) - 1)),
                               16'($urandom), 1'b0, UNTYPED);
                  else
                     send_item(OP_ACK, 16'($urandom), 16'($urandom), 1'b0, UNTYPED);
               end
               2: send_item(OP_ARRIVAL, ids[$urandom_range(0, i)], 16'($urandom),
                            1'b0, UNTYPED);
               3: send_item(OP_ARRIVAL,
                            16'(exp_id + 17'(WINDOW) + 17'($urandom_range(0, 40))),
                            16'($urandom), 1'b0, UNTYPED);
               default: send_item(OP_ARRIVAL, 16'($urandom), 16'($urandom),
                                  1'b0, UNTYPED);
            endcase
         end
         send_item(OP_ARRIVAL, ids[i], 16'($urandom), 1'b0, UNTYPED);
      end
   endtask

   // result beats cannot be held off: check each one on the edge that takes it
   always @(posedge clock) begin
      window_result_type want;
      if (!reset && rsp_strobe) begin
         if (due_wr == due_rd) begin
            $error("result beat kind %0d id 0x%0h with nothing expected",
                   rsp_kind, rsp_delivered_id);
            failed = 1'b1;
         end else begin
            want = due_take();
            check_field("kind",          32'(want.kind),   32'(rsp_kind));
            check_field("delivered_id",  32'(want.id),     32'(rsp_delivered_id));
            check_field("delivered_tag", 32'(want.tag),    32'(rsp_delivered_tag));
            check_field("ack_base",      32'(want.base),   32'(rsp_ack_base));
            check_field("ack_count",     32'(want.count),  32'(rsp_ack_count));
            check_field("ack_bitmap",    want.bitmap,      rsp_ack_bitmap);
            check_field("last",          32'(want.last),   32'(rsp_last));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      int limits [8];
      int stop_at;
      int r;
      reset          = 1'b1;
      start          = 1'b0;
      req_opcode     = OP_ARRIVAL;
      req_packet_id  = 16'd0;
      req_buffer_tag = 16'd0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = 6'd0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) send_item(plan[i].op, plan[i].id, plan[i].tag,
                                  plan[i].typed, plan[i].want);

      // 0 and anything above 32 are legal register values as well
      limits = '{1, 0, 63, 2, 31, 32, $urandom_range(1, 32), 17};
      foreach (limits[p]) begin
         wait_drained();
         @(negedge clock);
         csr_wr_en   <= 1'b1;
         csr_wr_data <= 6'(limits[p]);
         @(negedge clock);
         csr_wr_en   <= 1'b0;
         ack_lim = 6'(limits[p]);
         sender_gaps = ($urandom_range(0, 2) != 0);
         stop_at = items_sent + PHASE_ITEMS;
         while (items_sent < stop_at) begin
            r = $urandom_range(0, 19);
            if (r < 14) window_burst($urandom_range(1, 6), 1'b1);
            else if (r < 19) window_burst($urandom_range(7, WINDOW - 1), 1'b1);
            else window_burst(WINDOW, 1'b1);
         end
      end

      // short in-order run to close, back to back
      sender_gaps = 1'b0;
      stop_at = items_sent + TAIL_ITEMS;
      while (items_sent < stop_at) begin
         if (ID_SPACE - exp_id >= 17'(WINDOW) && $urandom_range(0, 7) == 0)
            window_burst($urandom_range(2, 8), 1'b0);
         else
            send_item(OP_ARRIVAL, exp_id[15:0], 16'($urandom), 1'b0, UNTYPED);
         if ($urandom_range(0, 15) == 0)
            send_item(OP_ACK, 16'($urandom), 16'($urandom), 1'b0, UNTYPED);
      end
      // a few closing beats: out of window, stale, random, and acks
      send_item(OP_ARRIVAL, 16'hFFFF, 16'($urandom), 1'b0, UNTYPED);
      send_item(OP_ARRIVAL, 16'h0000, 16'($urandom), 1'b0, UNTYPED);
      send_item(OP_ARRIVAL, 16'($urandom), 16'($urandom), 1'b0, UNTYPED);
      send_item(OP_ACK, 16'($urandom), 16'($urandom), 1'b0, UNTYPED);
      send_item(OP_ACK, 16'($urandom), 16'($urandom), 1'b0, UNTYPED);

      wait_drained();
      repeat (WINDOW + 4) @(posedge clock);
      if (!failed && due_wr == due_rd) begin
         $display("TEST PASSED");
      end else begin
         if (due_wr != due_rd)
            $error("%0d result beats never arrived", due_wr - due_rd);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
